[hw/rtl/vrbs_pkg.sv]
package vrbs_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned STACK_BYTES_DEF   = 1024;
  localparam int unsigned TRAILER_BYTES_DEF = 8;

  // Fixed field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FREE_W = 11;

  // Longest record, in bytes
  localparam logic [LEN_W-1:0] MAX_LEN = 7'd64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // One result, as the sequencer hands it to the output register
  typedef struct packed {
    logic              fire;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic              ok;
    logic              is_empty;
    logic [FREE_W-1:0] free_bytes;
  } vrbs_res_t;

endpackage

[hw/rtl/vrbs_ram.sv]
module vrbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/vrbs_sub.sv]
// Shared subtractor: a - b, both zero-extended by the caller; neg flags a < b.
module vrbs_sub #(
  parameter int unsigned W = 12
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         neg
);

  assign diff = a - b;
  assign neg  = diff[W-1];

endmodule

[hw/rtl/vrbs_ctrl.sv]
module vrbs_ctrl
  import vrbs_pkg::*;
#(
  parameter int unsigned STACK_BYTES   = STACK_BYTES_DEF,
  parameter int unsigned TRAILER_BYTES = TRAILER_BYTES_DEF,
  localparam int unsigned AW = $clog2(STACK_BYTES),
  localparam int unsigned TW = $clog2(STACK_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  command,
  input  logic [LEN_W-1:0]  length,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              out_free,
  output vrbs_res_t         res,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [BYTE_W-1:0] rd_data
);

  localparam int unsigned DW = TW + 1;
  localparam int unsigned CW = $clog2(TRAILER_BYTES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TRAIL = 4'd1;
  localparam logic [3:0] S_TRD   = 4'd2;
  localparam logic [3:0] S_CALC1 = 4'd3;
  localparam logic [3:0] S_CALC2 = 4'd4;
  localparam logic [3:0] S_RDA   = 4'd5;
  localparam logic [3:0] S_RDB   = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;

  logic [3:0]        state, state_next;
  logic [TW-1:0]     top, top_next;
  logic [TW-1:0]     ptr, ptr_next;
  logic [TW-1:0]     tpos, tpos_next;
  logic              push_active, push_active_next;
  logic              push_accepted, push_accepted_next;
  logic [LEN_W-1:0]  push_rem, push_rem_next;
  logic [LEN_W-1:0]  push_total, push_total_next;
  logic [LEN_W-1:0]  req_r, req_r_next;
  logic              is_pop, is_pop_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [BYTE_W-1:0] b0, b0_next;
  logic              hi_nz, hi_nz_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [LEN_W-1:0]  ncnt, ncnt_next;
  logic              ok_r, ok_r_next;

  logic [DW-1:0]     op_a, op_b, diff;
  logic              neg;
  logic [DW+FREE_W-1:0] diff_ext;

  logic              accept;
  logic [LEN_W-1:0]  req;
  logic              first;
  logic [LEN_W-1:0]  p_total, p_rem, p_rem_dec;
  logic              p_acc;
  logic [TW-1:0]     p_base;
  logic [LEN_W-1:0]  cap, nbytes;

  vrbs_sub #(.W(DW)) u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (diff),
    .neg  (neg)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign req      = (length > MAX_LEN) ? MAX_LEN : length;
  assign diff_ext = {{FREE_W{1'b0}}, diff};

  // Operand select for the shared subtractor
  always_comb begin
    op_a = DW'(STACK_BYTES);
    op_b = DW'(top);
    unique case (state)
      S_IDLE: begin
        if (command == CMD_PUSH) begin
          op_a = DW'(STACK_BYTES - TRAILER_BYTES);
          op_b = DW'(top);
        end else begin
          op_a = DW'(top);
          op_b = DW'(TRAILER_BYTES);
        end
      end
      S_CALC2: begin
        op_a = DW'(tpos);
        op_b = DW'(len);
      end
      default: begin
        op_a = DW'(STACK_BYTES);
        op_b = DW'(top);
      end
    endcase
  end

  // Push bookkeeping for the item at the input
  assign first     = !push_active;
  assign p_total   = first ? req : push_total;
  assign p_rem     = first ? req : push_rem;
  assign p_acc     = first ? (!neg && (DW'(req) <= diff)) : push_accepted;
  assign p_base    = first ? top : ptr;
  assign p_rem_dec = (p_rem != '0) ? p_rem - 7'd1 : p_rem;

  assign cap    = (hi_nz || (b0 > BYTE_W'(MAX_LEN))) ? MAX_LEN : b0[LEN_W-1:0];
  assign nbytes = (req_r < len) ? req_r : len;

  always_comb begin
    state_next         = state;
    top_next           = top;
    ptr_next           = ptr;
    tpos_next          = tpos;
    push_active_next   = push_active;
    push_accepted_next = push_accepted;
    push_rem_next      = push_rem;
    push_total_next    = push_total;
    req_r_next         = req_r;
    is_pop_next        = is_pop;
    cnt_next           = cnt;
    b0_next            = b0;
    hi_nz_next         = hi_nz;
    len_next           = len;
    ncnt_next          = ncnt;
    ok_r_next          = ok_r;
    wr_en              = 1'b0;
    wr_addr            = ptr[AW-1:0];
    wr_data            = '0;
    rd_en              = 1'b0;
    rd_addr            = ptr[AW-1:0];
    res                = '0;
    res.is_empty       = (top == '0);
    res.free_bytes     = diff_ext[FREE_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_PUSH: begin
              push_total_next    = p_total;
              push_accepted_next = p_acc;
              push_rem_next      = p_rem_dec;
              ptr_next           = p_base;
              if (p_rem != '0) begin
                wr_en    = p_acc;
                wr_addr  = p_base[AW-1:0];
                wr_data  = data_byte;
                ptr_next = p_base + TW'(1);
              end
              if (p_rem_dec == '0) begin
                push_active_next = 1'b0;
                ok_r_next        = p_acc;
                cnt_next         = '0;
                state_next       = p_acc ? S_TRAIL : S_EMIT;
              end else begin
                push_active_next = 1'b1;
              end
            end
            CMD_CLEAR: begin
              push_active_next = 1'b0;
              push_rem_next    = '0;
              top_next         = '0;
              ok_r_next        = 1'b1;
              state_next       = S_EMIT;
            end
            CMD_POP, CMD_PEEK: begin
              push_active_next = 1'b0;
              push_rem_next    = '0;
              req_r_next       = req;
              is_pop_next      = (command == CMD_POP);
              if (neg) begin
                ok_r_next  = 1'b0;
                state_next = S_EMIT;
              end else begin
                tpos_next  = diff[TW-1:0];
                ptr_next   = diff[TW-1:0];
                cnt_next   = '0;
                b0_next    = '0;
                hi_nz_next = 1'b0;
                state_next = S_TRD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // Length trailer: low byte holds the length, the rest are zero
      S_TRAIL: begin
        wr_en    = 1'b1;
        wr_data  = (cnt == '0) ? BYTE_W'(push_total) : '0;
        ptr_next = ptr + TW'(1);
        cnt_next = cnt + CW'(1);
        if (cnt == CW'(TRAILER_BYTES - 1)) begin
          top_next   = ptr + TW'(1);
          state_next = S_EMIT;
        end
      end

      // Trailer read: issue on cnt 0..T-1, collect on cnt 1..T
      S_TRD: begin
        if (cnt != CW'(TRAILER_BYTES)) begin
          rd_en    = 1'b1;
          ptr_next = ptr + TW'(1);
        end
        if (cnt == CW'(1)) begin
          b0_next = rd_data;
        end else if (cnt != '0) begin
          hi_nz_next = hi_nz || (rd_data != '0);
        end
        cnt_next = cnt + CW'(1);
        if (cnt == CW'(TRAILER_BYTES)) begin
          state_next = S_CALC1;
        end
      end

      S_CALC1: begin
        len_next   = (tpos < TW'(cap)) ? tpos[LEN_W-1:0] : cap;
        state_next = S_CALC2;
      end

      S_CALC2: begin
        ptr_next  = diff[TW-1:0];
        ncnt_next = nbytes;
        if (is_pop) begin
          top_next = diff[TW-1:0];
        end
        if (nbytes == '0) begin
          ok_r_next  = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_RDA;
        end
      end

      S_RDA: begin
        rd_en      = 1'b1;
        state_next = S_RDB;
      end

      S_RDB: begin
        if (out_free) begin
          res.fire       = 1'b1;
          res.out_byte   = rd_data;
          res.byte_valid = 1'b1;
          res.last       = (ncnt == 7'd1);
          res.ok         = 1'b1;
          ptr_next       = ptr + TW'(1);
          ncnt_next      = ncnt - 7'd1;
          state_next     = (ncnt == 7'd1) ? S_IDLE : S_RDA;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          res.fire   = 1'b1;
          res.last   = 1'b1;
          res.ok     = ok_r;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      top           <= '0;
      push_active   <= 1'b0;
      push_accepted <= 1'b0;
      push_rem      <= '0;
      push_total    <= '0;
      cnt           <= '0;
      ncnt          <= '0;
    end else begin
      state         <= state_next;
      top           <= top_next;
      push_active   <= push_active_next;
      push_accepted <= push_accepted_next;
      push_rem      <= push_rem_next;
      push_total    <= push_total_next;
      cnt           <= cnt_next;
      ncnt          <= ncnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    tpos   <= tpos_next;
    req_r  <= req_r_next;
    is_pop <= is_pop_next;
    b0     <= b0_next;
    hi_nz  <= hi_nz_next;
    len    <= len_next;
    ok_r   <= ok_r_next;
  end

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    top <= TW'(STACK_BYTES))
    else $error("top of stack beyond store");
  a_wr_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE || state == S_TRAIL))
    else $error("store write outside push");
  a_stream_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDA || state == S_RDB) |-> (ncnt != '0))
    else $error("byte stream with nothing left");
`endif

endmodule

[hw/rtl/variable_record_byte_stack_unit.sv]
// Channel | valid    | stall     | payload
// --------+----------+-----------+------------------------------------------------
// input   | in_valid | in_stall  | command, length, data_byte
// output  | out_valid| out_stall | out_byte, byte_valid, last, ok, is_empty, free_bytes
//
// Push data byte: written straight from the input; the completing item adds TRAILER_BYTES
// trailer writes (accepted push only), then hands its result to the output register.
// Pop/peek: trailer reads, the length steps CALC1 and CALC2, then each byte is read and
// delivered through the single registered read port; clear goes straight to its result.
// rst (synchronous) empties the stack and drops any push in progress; store
// contents are not cleared. Output stalls hold the sequencer at its result step.
module variable_record_byte_stack_unit
  import vrbs_pkg::*;
#(
  parameter int unsigned STACK_BYTES   = STACK_BYTES_DEF,
  parameter int unsigned TRAILER_BYTES = TRAILER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  command,
  input  logic [LEN_W-1:0]  length,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              byte_valid,
  output logic              last,
  output logic              ok,
  output logic              is_empty,
  output logic [FREE_W-1:0] free_bytes
);

  localparam int unsigned AW = $clog2(STACK_BYTES);

  vrbs_res_t         res;
  logic              out_free;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;

  // Output register frees up when empty or when its item leaves this cycle
  assign out_free = !out_valid || !out_stall;

  // Sequencer: push bookkeeping, trailer walk, byte stream
  vrbs_ctrl #(
    .STACK_BYTES   (STACK_BYTES),
    .TRAILER_BYTES (TRAILER_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .length    (length),
    .data_byte (data_byte),
    .out_free  (out_free),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Byte store: records plus their length trailers, growing upward
  vrbs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STACK_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fire) begin
      out_byte   <= res.out_byte;
      byte_valid <= res.byte_valid;
      last       <= res.last;
      ok         <= res.ok;
      is_empty   <= res.is_empty;
      free_bytes <= res.free_bytes;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.fire |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting item");
`endif

endmodule

[dv/tb_top.sv]
module tb_top
  import vrbs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Block configuration under test
  localparam int unsigned SB = STACK_BYTES_DEF;
  localparam int unsigned TB = TRAILER_BYTES_DEF;

  // Longest random idle burst, for sender gaps and receiver stalls
  localparam int unsigned BURST_MAX = 11;
  // Receiver hold-off that backs the block up into its input
  localparam int unsigned LONG_HOLD = 300;
  // Drain allowance after the last result
  localparam int unsigned DRAIN_CYCLES = 200;
  // Random phase length, in input items
  localparam int unsigned MIX_ITEMS = 24;
  // Idle-free closing phase length, in input items
  localparam int unsigned TAIL_ITEMS = 12;

  // One result item, field by field
  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic              ok;
    logic              is_empty;
    logic [FREE_W-1:0] free_bytes;
  } stack_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  command = CMD_PUSH;
  logic [LEN_W-1:0]  length = '0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              last;
  logic              ok;
  logic              is_empty;
  logic [FREE_W-1:0] free_bytes;

  // Idle controls for the sender and the receiver
  bit gap_on = 1'b1;
  bit stall_on = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned stall_left = 0;

  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;

  // Results still owed by the block, oldest first
  stack_result_t pending_results[$];
  stack_result_t want;

  // Shadow copy of the stack
  logic [7:0]  stack_mem [SB];
  int unsigned top_idx = 0;
  bit          rec_open = 1'b0;
  bit          rec_fits = 1'b0;
  int unsigned rec_left = 0;
  int unsigned rec_len = 0;

  variable_record_byte_stack_unit #(
    .STACK_BYTES  (SB),
    .TRAILER_BYTES(TB)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .length    (length),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .byte_valid(byte_valid),
    .last      (last),
    .ok        (ok),
    .is_empty  (is_empty),
    .free_bytes(free_bytes)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Queue one expected result; empty flag and free space as the stack stands now
  function automatic void owe_result(logic [BYTE_W-1:0] b, bit v, bit lst, bit good);
    stack_result_t r;
    r.out_byte   = v ? b : '0;
    r.byte_valid = v;
    r.last       = lst;
    r.ok         = good;
    r.is_empty   = (top_idx == 0);
    r.free_bytes = FREE_W'(SB - top_idx);
    pending_results.push_back(r);
  endfunction

  // Apply one accepted input item to the shadow stack and queue what it causes
  function automatic void predict_stack_op(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len_in,
                                           logic [BYTE_W-1:0] db);
    int unsigned req;
    int unsigned tpos;
    int unsigned start;
    int unsigned cnt;
    int          i;
    logic [63:0] stored;
    logic [63:0] len_word;
    req = (len_in > MAX_LEN) ? MAX_LEN : len_in;

    if (cmd == CMD_PUSH) begin
      // first item of a record decides whether it fits
      if (!rec_open) begin
        rec_open = 1'b1;
        rec_len  = req;
        rec_left = req;
        rec_fits = (req + TB) <= (SB - top_idx);
      end
      if (rec_left > 0) begin
        if (rec_fits) stack_mem[top_idx + rec_len - rec_left] = db;
        rec_left--;
      end
      if (rec_left > 0) return;
      rec_open = 1'b0;
      if (rec_fits) begin
        // little-endian length trailer right above the data
        len_word = rec_len;
        for (i = 0; i < TB; i++) stack_mem[top_idx + rec_len + i] = len_word[8*i +: 8];
        top_idx += rec_len + TB;
      end
      owe_result('0, 1'b0, 1'b1, rec_fits);
      return;
    end

    // anything else drops a partial record
    rec_open = 1'b0;
    rec_left = 0;

    if (cmd == CMD_CLEAR) begin
      top_idx = 0;
      owe_result('0, 1'b0, 1'b1, 1'b1);
      return;
    end

    if (top_idx < TB) begin
      owe_result('0, 1'b0, 1'b1, 1'b0);
      return;
    end

    tpos = top_idx - TB;
    stored = '0;
    for (i = TB - 1; i >= 0; i--) stored = {stored[55:0], stack_mem[tpos + i]};
    if (stored > MAX_LEN) stored = MAX_LEN;
    if (stored > tpos) stored = tpos;
    start = 32'(tpos - stored);
    cnt = (req < stored) ? req : 32'(stored);
    if (cmd == CMD_POP) top_idx = start;
    if (cnt == 0) begin
      owe_result('0, 1'b0, 1'b1, 1'b1);
      return;
    end
    for (i = 0; i < cnt; i++) owe_result(stack_mem[start + i], 1'b1, (i + 1) == cnt, 1'b1);
  endfunction

  // Offer one item, hold it until accepted, then predict it
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len,
                           logic [BYTE_W-1:0] db);
    int unsigned gap;
    gap = 0;
    if (gap_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, BURST_MAX);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    command   = cmd;
    length    = len;
    data_byte = db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_stack_op(cmd, len, db);
    items_sent++;
  endtask

  // First item carries the length; later ones get random (ignored) length fields
  task automatic push_record(int unsigned len_f, int unsigned n);
    int unsigned k;
    send_item(CMD_PUSH, LEN_W'(len_f), BYTE_W'($urandom));
    for (k = 1; k < n; k++) begin
      send_item(CMD_PUSH, LEN_W'($urandom_range(0, 127)), BYTE_W'($urandom));
    end
  endtask

  task automatic random_op();
    int unsigned pick;
    int unsigned r;
    int unsigned len_f;
    int unsigned eff;
    logic [CMD_W-1:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // mostly short records, a few at and past the cap
      r = $urandom_range(0, 19);
      if (r < 12) len_f = $urandom_range(0, 8);
      else if (r < 17) len_f = $urandom_range(9, 40);
      else if (r < 19) len_f = $urandom_range(41, 64);
      else len_f = $urandom_range(65, 127);
      eff = (len_f > MAX_LEN) ? MAX_LEN : len_f;
      if (eff > 1 && $urandom_range(0, 7) == 0) begin
        // cut the record short; next non-push command abandons it
        push_record(len_f, $urandom_range(1, eff - 1));
        case ($urandom_range(0, 2))
          0:       c = CMD_POP;
          1:       c = CMD_PEEK;
          default: c = CMD_CLEAR;
        endcase
        send_item(c, LEN_W'($urandom_range(0, 127)), BYTE_W'($urandom));
      end else begin
        push_record(len_f, eff);
      end
    end else begin
      if (pick < 73) c = CMD_PEEK;
      else if (pick < 96) c = CMD_POP;
      else c = CMD_CLEAR;
      len_f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
      send_item(c, LEN_W'(len_f), BYTE_W'($urandom));
    end
  endtask

  // Pop, peek and clear with nothing stored
  task automatic test_empty_stack();
    send_item(CMD_POP, 7'd3, 8'h00);
    send_item(CMD_PEEK, 7'd127, 8'hFF);
    send_item(CMD_CLEAR, 7'd0, 8'h00);
  endtask

  // Zero-length record, byte extremes, length saturation, zero byte count
  task automatic test_small_records();
    send_item(CMD_PUSH, 7'd0, 8'h5A);
    send_item(CMD_PEEK, 7'd5, 8'h00);
    send_item(CMD_PUSH, 7'd2, 8'h00);
    send_item(CMD_PUSH, 7'd127, 8'hFF);
    send_item(CMD_PEEK, 7'd127, 8'h00);
    send_item(CMD_PEEK, 7'd1, 8'h00);
    send_item(CMD_POP, 7'd0, 8'hFF);
    send_item(CMD_POP, 7'd64, 8'h00);
    send_item(CMD_POP, 7'd1, 8'h00);
    send_item(CMD_PUSH, 7'd3, 8'hA5);
    send_item(CMD_PUSH, 7'd0, 8'h5A);
    send_item(CMD_PUSH, 7'd64, 8'hFF);
    send_item(CMD_CLEAR, 7'd127, 8'hFF);
    send_item(CMD_PEEK, 7'd4, 8'h00);
  endtask

  // Partial records abandoned by peek, pop and clear
  task automatic test_broken_push();
    send_item(CMD_PUSH, 7'd1, 8'h3C);
    send_item(CMD_PUSH, 7'd4, 8'h11);
    send_item(CMD_PUSH, 7'd0, 8'h22);
    send_item(CMD_PEEK, 7'd64, 8'h00);
    send_item(CMD_POP, 7'd64, 8'h00);
    send_item(CMD_PUSH, 7'd9, 8'h77);
    send_item(CMD_POP, 7'd9, 8'h00);
    send_item(CMD_PUSH, 7'd2, 8'h88);
    send_item(CMD_CLEAR, 7'd0, 8'h00);
  endtask

  // Random operations with idle on/off stretches on both sides
  task automatic test_random_mix();
    int unsigned stop_at;
    stop_at = items_sent + MIX_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 24) == 0) gap_on = !gap_on;
      if ($urandom_range(0, 24) == 0) stall_on = !stall_on;
      random_op();
    end
    gap_on = 1'b1;
    stall_on = 1'b1;
  endtask

  // Fill the store to the last byte: refusal just past the fit, exact fit, refusal at full
  task automatic test_full_store();
    int unsigned len_f;
    int unsigned room;
    send_item(CMD_CLEAR, 7'd0, 8'h00);
    // records of 0 or 1 byte fill fastest per item; stops with TB..2*TB bytes left
    while ((SB - top_idx) >= 2 * TB + 1) begin
      len_f = $urandom_range(0, 1);
      push_record(len_f, len_f);
      if ($urandom_range(0, 31) == 0) begin
        send_item(CMD_PEEK, LEN_W'($urandom_range(0, 127)), BYTE_W'($urandom));
      end
    end
    room = SB - top_idx;
    push_record(room - TB + 1, room - TB + 1);
    push_record(room - TB, room - TB);
    send_item(CMD_PUSH, 7'd0, BYTE_W'($urandom));
    send_item(CMD_PUSH, 7'd1, BYTE_W'($urandom));
    send_item(CMD_PEEK, 7'd64, 8'h00);
    send_item(CMD_POP, 7'd127, 8'h00);
    send_item(CMD_POP, 7'd3, 8'h00);
    send_item(CMD_PEEK, 7'd0, 8'h00);
    send_item(CMD_CLEAR, 7'd0, 8'h00);
  endtask

  // Receiver holds off while peeks keep coming, so the input backs up
  task automatic test_output_hold();
    hold_cycles = LONG_HOLD;
    push_record(6, 6);
    repeat (3) send_item(CMD_PEEK, 7'd64, BYTE_W'($urandom));
    send_item(CMD_POP, 7'd127, BYTE_W'($urandom));
  endtask

  // No idling on either side at the end
  task automatic test_quiet_tail();
    int unsigned stop_at;
    gap_on = 1'b0;
    stall_on = 1'b0;
    stop_at = items_sent + TAIL_ITEMS;
    while (items_sent < stop_at) random_op();
    send_item(CMD_PEEK, 7'd64, BYTE_W'($urandom));
    send_item(CMD_CLEAR, 7'd0, BYTE_W'($urandom));
  endtask

  // Receiver: random stall bursts, plus the long hold when asked for
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(0, BURST_MAX - 1);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic void note_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // Every accepted result against the oldest one owed
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf({"result with none expected: byte=%02h bv=%0b last=%0b",
                              " ok=%0b empty=%0b free=%0d"},
                             out_byte, byte_valid, last, ok, is_empty, free_bytes));
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.out_byte || byte_valid !== want.byte_valid ||
            last !== want.last || ok !== want.ok || is_empty !== want.is_empty ||
            free_bytes !== want.free_bytes)
          note_error($sformatf({"mismatch: exp byte=%02h bv=%0b last=%0b ok=%0b empty=%0b free=%0d",
                                " / got byte=%02h bv=%0b last=%0b ok=%0b empty=%0b free=%0d"},
                               want.out_byte, want.byte_valid, want.last, want.ok,
                               want.is_empty, want.free_bytes, out_byte, byte_valid, last, ok,
                               is_empty, free_bytes));
      end
    end
  end

  // Hard stop well past the slowest legal run
  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_stack();
    test_small_records();
    test_broken_push();
    test_random_mix();
    test_full_store();
    test_output_hold();
    test_quiet_tail();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // catch anything extra the block still sends
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
